@@ design/plt_pkg.sv @@
package plt_pkg;

	localparam int CFG_BITS = 9;
	localparam int IDX_BITS = 8;
	localparam int SEG_OUT_BITS = 8;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_CLAMPED = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_O2T,
		OP_T2O,
		OP_CLAMP
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LO,
		S_HI,
		S_CLAMP,
		S_H1,
		S_H2,
		S_MID,
		S_P1,
		S_P2,
		S_PREP,
		S_PREP2,
		S_DIV
	} state_t;

endpackage

@@ design/plt_ram.sv @@
module plt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/plt_muldiv.sv @@
// floor(a * b / c) for a <= c, c > 0; one bit of b per cycle.
module plt_muldiv #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	output logic         done,
	output logic [W-1:0] q
);

	localparam int CNTW = $clog2(W + 1);

	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [W-1:0]    a_q, b_q, c_q, r_q, q_q;
	logic [W+1:0]    t, c1, c2;
	logic [W-1:0]    r_nx;
	logic [1:0]      k;
	logic            run;

	assign run = (cnt_q != '0);

	// remainder stays below c, so 2r + a stays below 3c
	always_comb begin
		t = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		c1 = {2'b00, c_q};
		c2 = {1'b0, c_q, 1'b0};
		if (t >= c2) begin
			r_nx = W'(t - c2);
			k = 2'd2;
		end else if (t >= c1) begin
			r_nx = W'(t - c1);
			k = 2'd1;
		end else begin
			r_nx = W'(t);
			k = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run && (cnt_q == CNTW'(1));
			if (start) begin
				cnt_q <= CNTW'(W);
			end else if (run) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			c_q <= c;
			r_q <= '0;
			q_q <= '0;
		end else if (run) begin
			r_q <= r_nx;
			q_q <= {q_q[W-2:0], 1'b0} + W'(k);
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign q = q_q;

endmodule

@@ design/plt_seq.sv @@
module plt_seq #(
	parameter int MAX_MARKERS = 256,
	parameter int POSITION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [plt_pkg::IDX_BITS-1:0]          entry_index,
	input  logic [POSITION_BITS-1:0]              entry_original,
	input  logic [POSITION_BITS-1:0]              entry_target,
	input  logic [POSITION_BITS-1:0]              position,
	input  logic [$clog2(MAX_MARKERS+1)-1:0]      n,
	input  logic                                  cfg_wr,
	output logic                                  ram_we,
	output logic [$clog2(MAX_MARKERS)-1:0]        ram_waddr,
	output logic [2*POSITION_BITS-1:0]            ram_wdata,
	output logic [$clog2(MAX_MARKERS)-1:0]        ram_raddr,
	input  logic [2*POSITION_BITS-1:0]            ram_rdata,
	output logic                                  div_start,
	output logic [POSITION_BITS-1:0]              div_a,
	output logic [POSITION_BITS-1:0]              div_b,
	output logic [POSITION_BITS-1:0]              div_c,
	input  logic                                  div_done,
	input  logic [POSITION_BITS-1:0]              div_q,
	output logic                                  done,
	output logic [POSITION_BITS-1:0]              result_position,
	output logic [plt_pkg::SEG_OUT_BITS-1:0]      segment_index,
	output logic [1:0]                            status
);

	import plt_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int AW = $clog2(MAX_MARKERS);
	localparam int CW = $clog2(MAX_MARKERS + 1);
	localparam int SW = AW + 2;

	state_t state_q, state_d;
	op_t    op_q;

	logic [PB-1:0] p_q, lo_q;
	logic [1:0]    stat_q;
	logic [2*PB-1:0] w0_q, w1_q;
	logic [AW-1:0] seg_q, mid_q, hint_idx_q;
	logic          hint_valid_q;
	logic signed [SW-1:0] first_q, last_q;
	logic [PB-1:0] span_q, offr_q, mag_q, d0_q;
	logic          neg_q;

	logic          done_q;
	logic [PB-1:0] res_q;
	logic [SEG_OUT_BITS-1:0] seg_out_q;
	logic [1:0]    status_q;

	logic [PB-1:0] rd_src, w0_src, w0_dst, w1_src, w1_dst;
	logic [PB-1:0] p_lo, p_clamp, p_upper;
	logic [1:0]    clamp_stat;
	logic          brk, go_up, hint_ok, acc;
	logic signed [SW-1:0] mid_sum, first_nx, last_nx;
	logic [AW-1:0] mid_w;
	logic [PB-1:0] span_d, offr_d, mag_d;
	logic          neg_d;

	logic          fin, set_hint, clr_hint;
	logic [PB-1:0] fin_res;
	logic [SEG_OUT_BITS-1:0] fin_seg;
	logic [1:0]    fin_stat;

	// memory word is {original, target}
	assign rd_src = (op_q == OP_O2T) ? ram_rdata[2*PB-1:PB] : ram_rdata[PB-1:0];
	assign w0_src = (op_q == OP_O2T) ? w0_q[2*PB-1:PB] : w0_q[PB-1:0];
	assign w0_dst = (op_q == OP_O2T) ? w0_q[PB-1:0] : w0_q[2*PB-1:PB];
	assign w1_src = (op_q == OP_O2T) ? w1_q[2*PB-1:PB] : w1_q[PB-1:0];
	assign w1_dst = (op_q == OP_O2T) ? w1_q[PB-1:0] : w1_q[2*PB-1:PB];

	assign acc = (state_q == S_IDLE) && start;
	assign busy = (state_q != S_IDLE);

	// a descending table can clamp low then high; the high bound wins
	always_comb begin
		p_lo = (p_q < lo_q) ? lo_q : p_q;
		p_clamp = (p_lo > rd_src) ? rd_src : p_lo;
		clamp_stat = ((p_q < lo_q) || (p_lo > rd_src)) ? STATUS_CLAMPED : STATUS_OK;
		p_upper = (p_q > rd_src) ? rd_src : p_q;
	end

	assign brk = (p_q >= w0_src) && (p_q <= rd_src);
	assign go_up = (p_q > rd_src);
	assign hint_ok = hint_valid_q && (CW'(hint_idx_q) <= (n - CW'(2)));

	assign mid_sum = first_q + last_q;
	assign mid_w = AW'(mid_sum >>> 1);
	assign first_nx = SW'(mid_q) + SW'(1);
	assign last_nx = SW'(mid_q) - SW'(1);

	always_comb begin
		span_d = w1_src - w0_src;
		offr_d = (p_q < w0_src) ? '0 : (p_q - w0_src);
		neg_d = (w1_dst < w0_dst);
		mag_d = neg_d ? (w0_dst - w1_dst) : (w1_dst - w0_dst);
	end

	assign ram_we = acc && (op == OP_WRITE) && (int'(entry_index) < MAX_MARKERS);
	assign ram_waddr = AW'(entry_index);
	assign ram_wdata = {entry_original, entry_target};

	assign div_a = (offr_q > span_q) ? span_q : offr_q;
	assign div_b = mag_q;
	assign div_c = span_q;

	always_comb begin
		state_d = state_q;
		ram_raddr = '0;
		div_start = 1'b0;
		fin = 1'b0;
		fin_res = '0;
		fin_seg = '0;
		fin_stat = STATUS_OK;
		set_hint = 1'b0;
		clr_hint = cfg_wr;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op == OP_WRITE) begin
						fin = 1'b1;
						clr_hint = 1'b1;
					end else if (n < CW'(3)) begin
						fin = 1'b1;
						fin_stat = STATUS_INVALID;
					end else if (op == OP_CLAMP) begin
						state_d = S_HI;
					end else begin
						state_d = S_LO;
					end
				end
			end
			S_LO: begin
				ram_raddr = '0;
				state_d = S_HI;
			end
			S_HI: begin
				ram_raddr = AW'(n - CW'(1));
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				if (op_q == OP_CLAMP) begin
					fin = 1'b1;
					fin_res = p_upper;
					fin_stat = (p_q > rd_src) ? STATUS_CLAMPED : STATUS_OK;
					state_d = S_IDLE;
				end else if (hint_ok) begin
					ram_raddr = hint_idx_q;
					state_d = S_H1;
				end else begin
					state_d = S_MID;
				end
			end
			S_H1: begin
				ram_raddr = AW'(hint_idx_q + AW'(1));
				state_d = S_H2;
			end
			S_H2: begin
				state_d = brk ? S_PREP : S_MID;
			end
			S_MID: begin
				ram_raddr = mid_w;
				state_d = S_P1;
			end
			S_P1: begin
				ram_raddr = AW'(mid_q + AW'(1));
				state_d = S_P2;
			end
			S_P2: begin
				if (brk) begin
					state_d = S_PREP;
				end else if (go_up) begin
					state_d = (first_nx > last_q) ? S_PREP : S_MID;
				end else begin
					state_d = (first_q > last_nx) ? S_PREP : S_MID;
				end
			end
			S_PREP: begin
				if (w1_src <= w0_src) begin
					fin = 1'b1;
					fin_res = w0_dst;
					fin_seg = SEG_OUT_BITS'(seg_q);
					fin_stat = stat_q;
					set_hint = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_PREP2;
				end
			end
			S_PREP2: begin
				div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					fin = 1'b1;
					fin_res = neg_q ? (d0_q - div_q) : (d0_q + div_q);
					fin_seg = SEG_OUT_BITS'(seg_q);
					fin_stat = stat_q;
					set_hint = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			hint_valid_q <= 1'b0;
			hint_idx_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (clr_hint) begin
				hint_valid_q <= 1'b0;
			end else if (set_hint) begin
				hint_valid_q <= 1'b1;
				hint_idx_q <= seg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fin_res;
			seg_out_q <= fin_seg;
			status_q <= fin_stat;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q <= op_t'(op);
					p_q <= position;
				end
			end
			S_HI: lo_q <= rd_src;
			S_CLAMP: begin
				p_q <= p_clamp;
				stat_q <= clamp_stat;
				first_q <= '0;
				last_q <= SW'(n) - SW'(2);
			end
			S_H1: w0_q <= ram_rdata;
			S_H2: begin
				w1_q <= ram_rdata;
				seg_q <= hint_idx_q;
			end
			S_MID: mid_q <= mid_w;
			S_P1: w0_q <= ram_rdata;
			S_P2: begin
				w1_q <= ram_rdata;
				seg_q <= mid_q;
				if (!brk) begin
					if (go_up) begin
						first_q <= first_nx;
					end else begin
						last_q <= last_nx;
					end
				end
			end
			S_PREP: begin
				span_q <= span_d;
				offr_q <= offr_d;
				neg_q <= neg_d;
				mag_q <= mag_d;
				d0_q <= w0_dst;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result_position = res_q;
	assign segment_index = seg_out_q;
	assign status = status_q;

endmodule

@@ design/piecewise_linear_time_remap.sv @@
// Piecewise-linear remap between an original and a target marker table.
// Command channel: an item (op, entry_index, entry_original, entry_target,
// position) is taken on a clock edge with start high and busy low. One
// result per item appears on result_position, segment_index and status
// for exactly one cycle, with done high; the receiver cannot stall it.
// Config channel: cfg_data (marker count) is written when cfg_valid and
// cfg_ready are both high; cfg_ready is low while an item is in progress
// or offered on start.
// Both tables sit in one shared RAM word per marker, one read per cycle.
// Writes and invalid tables raise done in the cycle after accept; clamp
// requests read the last target marker (S_HI) and finish in S_CLAMP.
// Conversions look up the span (S_LO, S_HI, S_CLAMP), then check a valid
// hint (S_H1, S_H2) and run binary search probes (S_MID, S_P1, S_P2) on a
// miss (up to log2(MAX_MARKERS) probes), then set up (S_PREP, S_PREP2),
// run the bit-serial multiply-divide (S_DIV) and output. A segment with
// zero source span skips the divide. One item at a time.
// Reset clears the marker count and the hint; table contents are undefined
// until written.
module piecewise_linear_time_remap #(
	parameter int MAX_MARKERS = 256,
	parameter int POSITION_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [plt_pkg::IDX_BITS-1:0]     entry_index,
	input  logic [POSITION_BITS-1:0]         entry_original,
	input  logic [POSITION_BITS-1:0]         entry_target,
	input  logic [POSITION_BITS-1:0]         position,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [plt_pkg::CFG_BITS-1:0]     cfg_data,
	output logic                             done,
	output logic [POSITION_BITS-1:0]         result_position,
	output logic [plt_pkg::SEG_OUT_BITS-1:0] segment_index,
	output logic [1:0]                       status
);

	import plt_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int AW = $clog2(MAX_MARKERS);
	localparam int CW = $clog2(MAX_MARKERS + 1);

	logic [CFG_BITS-1:0] count_q;
	logic [CW-1:0]       n_clip;
	logic                cfg_wr;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [2*PB-1:0] ram_wdata, ram_rdata;

	logic          div_start, div_done;
	logic [PB-1:0] div_a, div_b, div_c, div_q;

	// no count change on the edge that takes an item
	assign cfg_ready = !busy && !start;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		if (int'(count_q) > MAX_MARKERS) begin
			n_clip = CW'(MAX_MARKERS);
		end else begin
			n_clip = CW'(count_q);
		end
	end

	plt_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_MARKERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	plt_muldiv #(
		.W(PB)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (div_a),
		.b     (div_b),
		.c     (div_c),
		.done  (div_done),
		.q     (div_q)
	);

	plt_seq #(
		.MAX_MARKERS  (MAX_MARKERS),
		.POSITION_BITS(PB)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.entry_index    (entry_index),
		.entry_original (entry_original),
		.entry_target   (entry_target),
		.position       (position),
		.n              (n_clip),
		.cfg_wr         (cfg_wr),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.div_start      (div_start),
		.div_a          (div_a),
		.div_b          (div_b),
		.div_c          (div_c),
		.div_done       (div_done),
		.div_q          (div_q),
		.done           (done),
		.result_position(result_position),
		.segment_index  (segment_index),
		.status         (status)
	);

endmodule

@@ verif/piecewise_linear_time_remap_tb.sv @@
module piecewise_linear_time_remap_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import plt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 70;
	localparam int RANDOM_ITEMS = 950;
	localparam int TABLE_DEPTH = 256;

	typedef struct packed {
		logic [31:0] res_pos;
		logic [7:0]  seg;
		logic [1:0]  st;
	} remap_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  op = '0;
	logic [7:0]  entry_index = '0;
	logic [31:0] entry_original = '0;
	logic [31:0] entry_target = '0;
	logic [31:0] position = '0;
	logic        cfg_valid = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	wire         busy;
	wire         cfg_ready;
	wire         done;
	wire [31:0]  result_position;
	wire [7:0]   segment_index;
	wire [1:0]   status;

	// predictor copy of the block state
	logic [31:0] orig_marks [TABLE_DEPTH];
	logic [31:0] targ_marks [TABLE_DEPTH];
	bit          marks_written [TABLE_DEPTH];
	logic [7:0]  seg_hint = '0;
	bit          seg_hint_ok = 1'b0;
	int          marker_total = 0;

	remap_out_t  pending_remaps [$];
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;
	logic [31:0] last_pos [2] = '{32'h0, 32'h0};

	piecewise_linear_time_remap dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.entry_index(entry_index),
		.entry_original(entry_original),
		.entry_target(entry_target),
		.position(position),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.result_position(result_position),
		.segment_index(segment_index),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] src_mark(bit from_orig, int k);
		return from_orig ? orig_marks[k] : targ_marks[k];
	endfunction

	function automatic bit brackets_pos(bit from_orig, int k, logic [31:0] p);
		return p >= src_mark(from_orig, k) && p <= src_mark(from_orig, k + 1);
	endfunction

	function automatic int find_bracket(bit from_orig, int n, logic [31:0] p);
		int first = 0;
		int last = n - 2;
		int mid = 0;
		if (seg_hint_ok && seg_hint <= n - 2 && brackets_pos(from_orig, seg_hint, p))
			return seg_hint;
		while (first <= last) begin
			mid = (first + last) / 2;
			if (brackets_pos(from_orig, mid, p))
				return mid;
			if (p > src_mark(from_orig, mid + 1))
				first = mid + 1;
			else
				last = mid - 1;
		end
		// no bracket in a non-monotonic table: last probe wins
		return mid;
	endfunction

	function automatic logic [31:0] scale_div(logic [31:0] num, logic [31:0] gain,
			logic [31:0] den);
		logic [63:0] prod;
		prod = 64'(num) * 64'(gain);
		return 32'(prod / 64'(den));
	endfunction

	function automatic remap_out_t remap_item(op_t o, logic [7:0] idx, logic [31:0] eo,
			logic [31:0] et, logic [31:0] p_in);
		remap_out_t r;
		int n;
		int seg;
		bit from_orig;
		logic [31:0] p, lo, hi, s0, s1, d0, d1, span, off;
		r = '0;
		n = (marker_total > TABLE_DEPTH) ? TABLE_DEPTH : marker_total;
		if (o == OP_WRITE) begin
			orig_marks[idx] = eo;
			targ_marks[idx] = et;
			marks_written[idx] = 1'b1;
			seg_hint_ok = 1'b0;
			return r;
		end
		if (n < 3) begin
			r.st = STATUS_INVALID;
			return r;
		end
		p = p_in;
		r.st = STATUS_OK;
		if (o == OP_CLAMP) begin
			hi = targ_marks[n - 1];
			if (p > hi) begin
				p = hi;
				r.st = STATUS_CLAMPED;
			end
			r.res_pos = p;
			return r;
		end
		from_orig = (o == OP_O2T);
		lo = src_mark(from_orig, 0);
		hi = src_mark(from_orig, n - 1);
		if (p < lo) begin
			p = lo;
			r.st = STATUS_CLAMPED;
		end
		if (p > hi) begin
			p = hi;
			r.st = STATUS_CLAMPED;
		end
		seg = find_bracket(from_orig, n, p);
		s0 = src_mark(from_orig, seg);
		s1 = src_mark(from_orig, seg + 1);
		d0 = src_mark(!from_orig, seg);
		d1 = src_mark(!from_orig, seg + 1);
		if (s1 <= s0) begin
			r.res_pos = d0;
		end else begin
			span = s1 - s0;
			off = (p < s0) ? 32'h0 : p - s0;
			if (off > span)
				off = span;
			if (d1 >= d0)
				r.res_pos = d0 + scale_div(off, d1 - d0, span);
			else
				r.res_pos = d0 - scale_div(off, d0 - d1, span);
		end
		seg_hint = 8'(seg);
		seg_hint_ok = 1'b1;
		r.seg = 8'(seg);
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		remap_out_t want;
		if (arst_n && done) begin
			if (pending_remaps.size() == 0) begin
				$display("%0t: result with nothing pending: expected none, actual %h/%0d/%0d",
					$time, result_position, segment_index, status);
				mismatch_count++;
			end else begin
				want = pending_remaps.pop_front();
				if (result_position !== want.res_pos) begin
					$display("%0t: result_position expected %h actual %h",
						$time, want.res_pos, result_position);
					mismatch_count++;
				end
				if (segment_index !== want.seg) begin
					$display("%0t: segment_index expected %0d actual %0d",
						$time, want.seg, segment_index);
					mismatch_count++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// start stays high from one item to the next unless an idle gap is drawn
	task automatic send_item(op_t o, logic [7:0] idx, logic [31:0] eo, logic [31:0] et,
			logic [31:0] pos);
		while (idle_on && $urandom_range(99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		entry_index <= idx;
		entry_original <= eo;
		entry_target <= et;
		position <= pos;
		do @(posedge clk); while (busy !== 1'b0);
		pending_remaps.push_back(remap_item(o, idx, eo, et, pos));
		items_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_remaps.size() != 0) @(posedge clk);
	endtask

	task automatic set_marker_count(int n);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= CFG_BITS'(n);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		marker_total = n;
		seg_hint_ok = 1'b0;
	endtask

	function automatic int written_prefix();
		int k = 0;
		while (k < TABLE_DEPTH && marks_written[k])
			k++;
		return k;
	endfunction

	// rising original table, target rising or falling; some tables are pure noise
	task automatic load_markers(int n);
		int style;
		bit t_fall;
		logic [63:0] o_acc, t_acc;
		logic [31:0] o_max, t_max, d;
		style = $urandom_range(99);
		t_fall = ($urandom_range(3) == 0);
		o_acc = 64'($urandom_range(32'h4_0000, 0));
		t_acc = t_fall ? 64'(32'hFFFF_FFFF - $urandom_range(32'h4_0000, 0))
			: 64'($urandom_range(32'h4_0000, 0));
		o_max = (style < 55) ? 32'h3_0000 : 32'hFFFF_FFFF / n;
		t_max = (style < 55) ? 32'h3_0000 : 32'hFFFF_FFFF / n;
		for (int k = 0; k < n; k++) begin
			if (style < 15) begin
				send_item(OP_WRITE, 8'(k), $urandom & 32'h001F_FFFF, $urandom, $urandom);
			end else begin
				send_item(OP_WRITE, 8'(k), o_acc[31:0], t_acc[31:0], $urandom);
				if ($urandom_range(7) != 0) begin
					o_acc = o_acc + 64'($urandom_range(o_max, 0));
					if (o_acc > 64'hFFFF_FFFF)
						o_acc = 64'hFFFF_FFFF;
				end
				if ($urandom_range(7) != 0) begin
					d = $urandom_range(t_max, 0);
					if (!t_fall)
						t_acc = (t_acc + 64'(d) > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t_acc + 64'(d);
					else
						t_acc = (t_acc < 64'(d)) ? 64'h0 : t_acc - 64'(d);
				end
			end
		end
	endtask

	function automatic logic [31:0] pick_position(bit from_orig, int n);
		int r;
		int k;
		logic [31:0] a, b, lo_v, hi_v;
		logic [63:0] w;
		r = $urandom_range(99);
		if (n < 3)
			return $urandom;
		k = $urandom_range(n - 2, 0);
		a = src_mark(from_orig, k);
		b = src_mark(from_orig, k + 1);
		if (r < 35) begin
			lo_v = (a < b) ? a : b;
			hi_v = (a < b) ? b : a;
			w = 64'(hi_v) - 64'(lo_v) + 64'd1;
			return lo_v + 32'({$urandom, $urandom} % w);
		end else if (r < 50) begin
			return a;
		end else if (r < 72) begin
			// near the last query so the hint gets hit
			return last_pos[from_orig] + 32'($urandom_range(32'h200, 0)) - 32'h100;
		end else if (r < 82) begin
			return $urandom;
		end else if (r < 88) begin
			return src_mark(from_orig, 0) - 32'($urandom_range(32'hFFFF, 1));
		end else if (r < 94) begin
			return src_mark(from_orig, n - 1) + 32'($urandom_range(32'hFFFF, 1));
		end
		return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
	endfunction

	task automatic run_queries(int n, int cnt);
		int r;
		op_t o;
		logic [31:0] p;
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				send_item(OP_WRITE, 8'($urandom), $urandom, $urandom, $urandom);
			end else if (r < 6) begin
				drain_results();
			end else begin
				if (r < 50)
					o = OP_O2T;
				else if (r < 85)
					o = OP_T2O;
				else
					o = OP_CLAMP;
				p = pick_position(o == OP_O2T, n);
				last_pos[o == OP_O2T] = p;
				send_item(o, 8'($urandom), $urandom, $urandom, p);
			end
		end
	endtask

	task automatic test_unloaded_table();
		send_item(OP_O2T, 8'h00, 32'h0, 32'h0, 32'h0001_0000);
		send_item(OP_T2O, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLAMP, 8'h00, 32'h0, 32'h0, 32'h0);
		send_item(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_marker_count(2);
		send_item(OP_O2T, 8'h00, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_directed_segments();
		// seg 1 has zero original span, seg 2 falls in target
		send_item(OP_WRITE, 8'd0, 32'h0000_8000, 32'h0001_0000, 32'h0);
		send_item(OP_WRITE, 8'd1, 32'h0001_8000, 32'h0003_0000, 32'h0);
		send_item(OP_WRITE, 8'd2, 32'h0001_8000, 32'h0004_0000, 32'h0);
		send_item(OP_WRITE, 8'd3, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0);
		set_marker_count(4);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0000_0000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0000_8000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0001_0000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0001_0000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0001_8000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h8000_0000);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_item(OP_T2O, 8'd0, 32'h0, 32'h0, 32'h0001_8000);
		send_item(OP_T2O, 8'd0, 32'h0, 32'h0, 32'h0000_0000);
		send_item(OP_T2O, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_item(OP_CLAMP, 8'd0, 32'h0, 32'h0, 32'h0001_0000);
		send_item(OP_CLAMP, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_item(OP_CLAMP, 8'd0, 32'h0, 32'h0, 32'h0002_0000);
		// a write drops the hint
		send_item(OP_WRITE, 8'd0, 32'h0000_8000, 32'h0001_0000, 32'h0);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'h0001_0000);
		set_marker_count(3);
		send_item(OP_O2T, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_remaps();
		int phase;
		int n;
		int r;
		int stop_at;
		phase = 0;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			idle_on = !(phase >= 4 && phase < 9);
			r = $urandom_range(99);
			if (phase == 2) begin
				n = TABLE_DEPTH;
				load_markers(n);
			end else if (r < 6) begin
				n = $urandom_range(2, 0);
			end else if (r < 45 && written_prefix() >= 3) begin
				n = $urandom_range(written_prefix(), 3);
			end else begin
				n = $urandom_range(12, 3);
				load_markers(n);
			end
			set_marker_count(n);
			run_queries(n, $urandom_range(45, 20));
			phase++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unloaded_table();
		test_directed_segments();
		test_random_remaps();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_remaps.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
